[rtl/fcpq_pkg.sv]
// ============================================================================
// fcpq_pkg
// Types, codes and helper functions for the four-class priority queue.
// ============================================================================
`default_nettype none

package fcpq_pkg;

    localparam int CLASS_N     = 4;
    localparam int CLASS_W     = 2;
    localparam int TIME_W      = 11;
    localparam int COUNT_W     = 32;
    localparam int LEN_OUT_W   = 7;
    localparam int PEAK_OUT_W  = 9;

    localparam int MIN_PER_HOUR = 60;
    localparam int MIN_PER_DAY  = 24 * 60;
    localparam int MAX_HOUR     = 23;
    localparam int MAX_MINUTE   = 59;

    localparam logic [7:0] CHAR_V    = 8'h56;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_D    = 8'h44;
    localparam logic [7:0] CHAR_B    = 8'h42;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    localparam logic [CLASS_W-1:0] CLS_V = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_A = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_D = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_B = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_ARRIVE = 2'd0,
        OP_SERVE  = 2'd1,
        OP_STATUS = 2'd2,
        OP_REPORT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_TIME  = 3'd1,
        ST_BAD_PRIO  = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef struct packed {
        t_op         opcode;
        logic [7:0]  priority_letter;
        logic [4:0]  clock_hours;
        logic [5:0]  clock_minutes;
    } t_in_item;

    typedef struct packed {
        t_status              status_code;
        logic [6:0]           length_v;
        logic [6:0]           length_a;
        logic [6:0]           length_d;
        logic [6:0]           length_b;
        logic [COUNT_W-1:0]   served_count;
        logic [CLASS_W-1:0]   served_class;
        logic [TIME_W-1:0]    wait_minutes;
        logic [8:0]           peak_occupancy;
        logic [TIME_W-1:0]    longest_wait;
        logic [COUNT_W-1:0]   served_in_class;
    } t_out_item;

    typedef struct packed {
        logic                valid;
        logic [CLASS_W-1:0]  cls;
    } t_class_sel;

    // Letter to class, either case.
    function automatic t_class_sel letter_class(input logic [7:0] c);
        t_class_sel res;
        res.valid = 1'b1;
        res.cls   = CLS_V;
        if (c == CHAR_V || c == (CHAR_V | CASE_BIT)) begin
            res.cls = CLS_V;
        end else if (c == CHAR_A || c == (CHAR_A | CASE_BIT)) begin
            res.cls = CLS_A;
        end else if (c == CHAR_D || c == (CHAR_D | CASE_BIT)) begin
            res.cls = CLS_D;
        end else if (c == CHAR_B || c == (CHAR_B | CASE_BIT)) begin
            res.cls = CLS_B;
        end else begin
            res.valid = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [TIME_W-1:0] to_minutes(input logic [4:0] hh,
                                                     input logic [5:0] mm);
        return TIME_W'(hh) * TIME_W'(MIN_PER_HOUR) + TIME_W'(mm);
    endfunction

    // Wait over midnight wraps by one day.
    function automatic logic [TIME_W-1:0] wait_calc(input logic [TIME_W-1:0] now,
                                                    input logic [TIME_W-1:0] arr);
        logic [TIME_W:0] diff;
        if (now >= arr) begin
            diff = {1'b0, now} - {1'b0, arr};
        end else begin
            diff = {1'b0, now} + (TIME_W+1)'(MIN_PER_DAY) - {1'b0, arr};
        end
        return diff[TIME_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

[rtl/fcpq_ram.sv]
// ============================================================================
// fcpq_ram
// Arrival time store: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module fcpq_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 11
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/four_class_priority_queue_wait_stats.sv]
// ============================================================================
// four_class_priority_queue_wait_stats
// Four FIFO classes (V, A, D, B) served in strict priority, with wait stats.
// ============================================================================
// Usage:
//   Requests enter on i_in_valid / o_in_ready with i_in_item; one result per
//   request leaves on o_out_valid / i_out_ready with o_out_item.
//   A request accepted in S_IDLE moves to S_EXEC, and its result is registered
//   when it leaves S_EXEC. No new request is taken until then. S_EXEC waits for the
//   synchronous read of the head entry in the arrival store, which is issued
//   at accept time for the highest non-empty class.
//   A new request is accepted while the previous result still sits in the
//   output register. If that register is still full when the next result is
//   done, the block holds the request until the receiver takes the old one.
//   Reset (synchronous, active low) clears pointers, lengths, peak, longest
//   wait and served counters. The arrival store is not cleared: a head entry is
//   used only after it has been written, so no clearing pass is needed.
// ============================================================================
`default_nettype none

module four_class_priority_queue_wait_stats #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  fcpq_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output fcpq_pkg::t_out_item   o_out_item
);
    import fcpq_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = $clog2(4 * QUEUE_DEPTH + 1);
    localparam int AW = PW + CLASS_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [LW-1:0] LEN_FULL = LW'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state              r_state, n_state;
    t_in_item            r_req;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_item, n_out_item;

    logic [PW-1:0]       r_head [CLASS_N];
    logic [PW-1:0]       n_head [CLASS_N];
    logic [PW-1:0]       r_tail [CLASS_N];
    logic [PW-1:0]       n_tail [CLASS_N];
    logic [LW-1:0]       r_len  [CLASS_N];
    logic [LW-1:0]       n_len  [CLASS_N];
    logic [COUNT_W-1:0]  r_served_cls [CLASS_N];
    logic [COUNT_W-1:0]  n_served_cls [CLASS_N];
    logic [TW-1:0]       r_total, n_total;
    logic [TW-1:0]       r_peak, n_peak;
    logic [TIME_W-1:0]   r_max_wait, n_max_wait;
    logic [COUNT_W-1:0]  r_served_total, n_served_total;

    logic                in_accept;
    logic                out_free;
    logic                commit;
    logic                any_busy;
    logic [CLASS_W-1:0]  sel_cls;
    t_class_sel          letter;
    logic                time_ok;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   head_arr;
    logic [TIME_W-1:0]   wait_val;
    logic                wr_en;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign commit      = (r_state == S_EXEC) && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Highest non-empty class; lengths do not move between accept and commit.
    always_comb begin
        any_busy = 1'b1;
        if (r_len[CLS_V] != '0) begin
            sel_cls = CLS_V;
        end else if (r_len[CLS_A] != '0) begin
            sel_cls = CLS_A;
        end else if (r_len[CLS_D] != '0) begin
            sel_cls = CLS_D;
        end else begin
            sel_cls  = CLS_B;
            any_busy = (r_len[CLS_B] != '0);
        end
    end

    fcpq_ram #(
        .ADDR_W (AW),
        .DATA_W (TIME_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr ({letter.cls, r_tail[letter.cls]}),
        .i_wr_data (now),
        .i_rd_en   (in_accept),
        .i_rd_addr ({sel_cls, r_head[sel_cls]}),
        .o_rd_data (head_arr)
    );

    assign letter   = letter_class(r_req.priority_letter);
    assign time_ok  = (r_req.clock_hours <= 5'(MAX_HOUR))
                   && (r_req.clock_minutes <= 6'(MAX_MINUTE));
    assign now      = to_minutes(r_req.clock_hours, r_req.clock_minutes);
    assign wait_val = wait_calc(now, head_arr);

    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_len          = r_len;
        n_served_cls   = r_served_cls;
        n_total        = r_total;
        n_peak         = r_peak;
        n_max_wait     = r_max_wait;
        n_served_total = r_served_total;
        wr_en          = 1'b0;

        n_out_item              = '0;
        n_out_item.status_code  = ST_OK;

        case (r_req.opcode)
            OP_ARRIVE: begin
                if (!time_ok) begin
                    n_out_item.status_code = ST_BAD_TIME;
                end else if (!letter.valid) begin
                    n_out_item.status_code = ST_BAD_PRIO;
                end else if (r_len[letter.cls] >= LEN_FULL) begin
                    n_out_item.status_code = ST_FULL;
                end else begin
                    wr_en = commit;
                    n_tail[letter.cls] = (r_tail[letter.cls] == PTR_LAST)
                                       ? '0 : r_tail[letter.cls] + PW'(1);
                    n_len[letter.cls]  = r_len[letter.cls] + LW'(1);
                    n_total            = r_total + TW'(1);
                    if (n_total > r_peak) begin
                        n_peak = n_total;
                    end
                end
            end
            OP_SERVE: begin
                if (!time_ok) begin
                    n_out_item.status_code = ST_BAD_TIME;
                end else if (!any_busy) begin
                    n_out_item.status_code = ST_EMPTY;
                end else begin
                    n_head[sel_cls] = (r_head[sel_cls] == PTR_LAST)
                                    ? '0 : r_head[sel_cls] + PW'(1);
                    n_len[sel_cls]  = r_len[sel_cls] - LW'(1);
                    n_total         = r_total - TW'(1);
                    if (wait_val > r_max_wait) begin
                        n_max_wait = wait_val;
                    end
                    n_served_cls[sel_cls]   = sat_inc(r_served_cls[sel_cls]);
                    n_served_total          = sat_inc(r_served_total);
                    n_out_item.served_class = sel_cls;
                    n_out_item.wait_minutes = wait_val;
                end
            end
            OP_STATUS: begin
            end
            OP_REPORT: begin
                if (!letter.valid) begin
                    n_out_item.status_code = ST_BAD_PRIO;
                end else begin
                    n_out_item.served_in_class = r_served_cls[letter.cls];
                end
            end
            default: begin
            end
        endcase

        n_out_item.length_v       = LEN_OUT_W'(n_len[CLS_V]);
        n_out_item.length_a       = LEN_OUT_W'(n_len[CLS_A]);
        n_out_item.length_d       = LEN_OUT_W'(n_len[CLS_D]);
        n_out_item.length_b       = LEN_OUT_W'(n_len[CLS_B]);
        n_out_item.served_count   = n_served_total;
        n_out_item.peak_occupancy = PEAK_OUT_W'(n_peak);
        n_out_item.longest_wait   = n_max_wait;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_total        <= '0;
            r_peak         <= '0;
            r_max_wait     <= '0;
            r_served_total <= '0;
            for (int k = 0; k < CLASS_N; k++) begin
                r_head[k]       <= '0;
                r_tail[k]       <= '0;
                r_len[k]        <= '0;
                r_served_cls[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (commit) begin
                r_head         <= n_head;
                r_tail         <= n_tail;
                r_len          <= n_len;
                r_served_cls   <= n_served_cls;
                r_total        <= n_total;
                r_peak         <= n_peak;
                r_max_wait     <= n_max_wait;
                r_served_total <= n_served_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in_item;
        end
        if (commit) begin
            r_out_item <= n_out_item;
        end
    end

    // ------------------------------------------------------------------------
    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total == TW'(r_len[CLS_V]) + TW'(r_len[CLS_A])
                 + TW'(r_len[CLS_D]) + TW'(r_len[CLS_B]))
        else $error("waiting total differs from sum of class lengths");

    a_peak_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_total)
        else $error("peak occupancy below current total");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len[CLS_V] <= LEN_FULL && r_len[CLS_A] <= LEN_FULL
        && r_len[CLS_D] <= LEN_FULL && r_len[CLS_B] <= LEN_FULL)
        else $error("class length beyond queue depth");

    a_exec_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !out_free) |=> (r_state == S_EXEC))
        else $error("request left execute while output was blocked");

    a_wait_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.wait_minutes <= TIME_W'(MIN_PER_DAY - 1)))
        else $error("wait out of range");

endmodule

`default_nettype wire
